// File: rtl/sle_pkg.sv
// shared types and constants for the sequential list engine
// no dependencies; compiled before every other file

package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = 7;
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int ST_W     = 2;
    localparam int STEP_W   = 5;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE  = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] LO_KEEP  = 3'd0;
    localparam logic [2:0] LO_INC   = 3'd1;
    localparam logic [2:0] LO_DEC   = 3'd2;
    localparam logic [2:0] LO_ZERO  = 3'd3;
    localparam logic [2:0] LO_LENM1 = 3'd4;
    localparam logic [2:0] LO_POS   = 3'd5;
    localparam logic [2:0] LO_PM1   = 3'd6;

    localparam logic [2:0] HI_KEEP  = 3'd0;
    localparam logic [2:0] HI_INC   = 3'd1;
    localparam logic [2:0] HI_DEC   = 3'd2;
    localparam logic [2:0] HI_LEN   = 3'd3;
    localparam logic [2:0] HI_LENM1 = 3'd4;
    localparam logic [2:0] HI_PM1   = 3'd5;

    localparam logic [1:0] LEN_KEEP = 2'd0;
    localparam logic [1:0] LEN_INC  = 2'd1;
    localparam logic [1:0] LEN_DEC  = 2'd2;

    localparam logic WA_LO = 1'b0;
    localparam logic WA_HI = 1'b1;

    localparam logic [1:0] WD_VAL = 2'd0;
    localparam logic [1:0] WD_RDA = 2'd1;
    localparam logic [1:0] WD_RDB = 2'd2;

    localparam logic [3:0] C_NEVER       = 4'd0;
    localparam logic [3:0] C_ALWAYS      = 4'd1;
    localparam logic [3:0] C_FULL        = 4'd2;
    localparam logic [3:0] C_BAD_INS     = 4'd3;
    localparam logic [3:0] C_BAD_POS     = 4'd4;
    localparam logic [3:0] C_HI_EQ_PM1   = 4'd5;
    localparam logic [3:0] C_HI_EQ_POS   = 4'd6;
    localparam logic [3:0] C_LO_EQ_LEN   = 4'd7;
    localparam logic [3:0] C_LO_EQ_LENM1 = 4'd8;
    localparam logic [3:0] C_MISS_MORE   = 4'd9;
    localparam logic [3:0] C_MATCH       = 4'd10;
    localparam logic [3:0] C_LEN_LT2     = 4'd11;
    localparam logic [3:0] C_REV_MORE    = 4'd12;

    typedef struct packed {
        logic [2:0]        lo_op;
        logic [2:0]        hi_op;
        logic              rd_en;
        logic              wr_en;
        logic              wa_sel;
        logic [1:0]        wd_sel;
        logic [1:0]        len_op;
        logic              st_en;
        logic [ST_W-1:0]   st_code;
        logic              found_en;
        logic              rdval_en;
        logic              done;
        logic [3:0]        cond;
        logic              pol;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic full;
        logic bad_ins;
        logic bad_pos;
        logic hi_eq_pm1;
        logic hi_eq_pos;
        logic lo_eq_len;
        logic lo_eq_lenm1;
        logic miss_more;
        logic match;
        logic len_lt2;
        logic rev_more;
    } t_flags;

endpackage

// File: rtl/sle_if.sv
// command and response channel interfaces of the list engine
// depends on sle_pkg for field widths

interface sle_cmd_if;
    import sle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [LEN_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface sle_rsp_if;
    import sle_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;

    modport source (
        output valid, output status, output found_position,
        output read_value, output list_length, input ready
    );
    modport sink (
        input valid, input status, input found_position,
        input read_value, input list_length, output ready
    );
endinterface

// File: rtl/sle_seq.sv
// microcode sequencer: step counter, control rom, dispatch and conditional jumps
// depends on sle_pkg for the control word, flags and codes

module sle_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [sle_pkg::OP_W-1:0] i_op,
    input  sle_pkg::t_flags         i_flags,
    input  logic                    i_out_free,
    output sle_pkg::t_uword         o_ctl,
    output logic                    o_exec,
    output logic                    o_out_load,
    output logic                    o_busy
);
    import sle_pkg::*;

    localparam logic [STEP_W-1:0] S_AP0  = 5'd0;
    localparam logic [STEP_W-1:0] S_AP1  = 5'd1;
    localparam logic [STEP_W-1:0] S_IN0  = 5'd2;
    localparam logic [STEP_W-1:0] S_IN1  = 5'd3;
    localparam logic [STEP_W-1:0] S_IN2  = 5'd4;
    localparam logic [STEP_W-1:0] S_IN3  = 5'd5;
    localparam logic [STEP_W-1:0] S_IN4  = 5'd6;
    localparam logic [STEP_W-1:0] S_IN5  = 5'd7;
    localparam logic [STEP_W-1:0] S_DL0  = 5'd8;
    localparam logic [STEP_W-1:0] S_DL1  = 5'd9;
    localparam logic [STEP_W-1:0] S_DL2  = 5'd10;
    localparam logic [STEP_W-1:0] S_DL3  = 5'd11;
    localparam logic [STEP_W-1:0] S_DL4  = 5'd12;
    localparam logic [STEP_W-1:0] S_LC0  = 5'd13;
    localparam logic [STEP_W-1:0] S_LC1  = 5'd14;
    localparam logic [STEP_W-1:0] S_LC2  = 5'd15;
    localparam logic [STEP_W-1:0] S_LC3  = 5'd16;
    localparam logic [STEP_W-1:0] S_LC4  = 5'd17;
    localparam logic [STEP_W-1:0] S_LNF  = 5'd18;
    localparam logic [STEP_W-1:0] S_LFD  = 5'd19;
    localparam logic [STEP_W-1:0] S_RV0  = 5'd20;
    localparam logic [STEP_W-1:0] S_RV1  = 5'd21;
    localparam logic [STEP_W-1:0] S_RV2  = 5'd22;
    localparam logic [STEP_W-1:0] S_RV3  = 5'd23;
    localparam logic [STEP_W-1:0] S_DONE = 5'd24;
    localparam logic [STEP_W-1:0] S_RD0  = 5'd25;
    localparam logic [STEP_W-1:0] S_RD1  = 5'd26;
    localparam logic [STEP_W-1:0] S_RD2  = 5'd27;
    localparam logic [STEP_W-1:0] S_FULL = 5'd28;
    localparam logic [STEP_W-1:0] S_BAD  = 5'd29;
    localparam int                N_STEPS = 30;

    function automatic t_uword rom(input logic [STEP_W-1:0] a);
        t_uword w;
        w = '0;
        case (a)
            S_AP0: begin
                w.hi_op = HI_LEN;
                w.cond = C_FULL; w.target = S_FULL;
            end
            S_AP1: begin
                w.wr_en = 1'b1; w.wa_sel = WA_HI; w.wd_sel = WD_VAL;
                w.len_op = LEN_INC;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_IN0: begin
                w.lo_op = LO_LENM1; w.hi_op = HI_LEN;
                w.cond = C_FULL; w.target = S_FULL;
            end
            S_IN1: begin
                w.cond = C_BAD_INS; w.target = S_BAD;
            end
            S_IN2: begin
                w.cond = C_HI_EQ_PM1; w.target = S_IN5;
            end
            S_IN3: begin
                w.rd_en = 1'b1;
            end
            S_IN4: begin
                w.wr_en = 1'b1; w.wa_sel = WA_HI; w.wd_sel = WD_RDA;
                w.lo_op = LO_DEC; w.hi_op = HI_DEC;
                w.cond = C_HI_EQ_POS; w.pol = 1'b1; w.target = S_IN3;
            end
            S_IN5: begin
                w.wr_en = 1'b1; w.wa_sel = WA_HI; w.wd_sel = WD_VAL;
                w.len_op = LEN_INC;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_DL0: begin
                w.lo_op = LO_POS; w.hi_op = HI_PM1;
                w.cond = C_BAD_POS; w.target = S_BAD;
            end
            S_DL1: begin
                w.cond = C_LO_EQ_LEN; w.target = S_DL4;
            end
            S_DL2: begin
                w.rd_en = 1'b1;
            end
            S_DL3: begin
                w.wr_en = 1'b1; w.wa_sel = WA_HI; w.wd_sel = WD_RDA;
                w.lo_op = LO_INC; w.hi_op = HI_INC;
                w.cond = C_LO_EQ_LENM1; w.pol = 1'b1; w.target = S_DL2;
            end
            S_DL4: begin
                w.len_op = LEN_DEC;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_LC0: begin
                w.lo_op = LO_ZERO;
            end
            S_LC1: begin
                w.cond = C_LO_EQ_LEN; w.target = S_LNF;
            end
            S_LC2: begin
                w.rd_en = 1'b1; w.lo_op = LO_INC;
            end
            S_LC3: begin
                w.cond = C_MISS_MORE; w.target = S_LC2;
            end
            S_LC4: begin
                w.cond = C_MATCH; w.target = S_LFD;
            end
            S_LNF: begin
                w.st_en = 1'b1; w.st_code = ST_NOTFOUND;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_LFD: begin
                w.found_en = 1'b1;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_RV0: begin
                w.lo_op = LO_ZERO; w.hi_op = HI_LENM1;
                w.cond = C_LEN_LT2; w.target = S_DONE;
            end
            S_RV1: begin
                w.rd_en = 1'b1;
            end
            S_RV2: begin
                w.wr_en = 1'b1; w.wa_sel = WA_LO; w.wd_sel = WD_RDB;
            end
            S_RV3: begin
                w.wr_en = 1'b1; w.wa_sel = WA_HI; w.wd_sel = WD_RDA;
                w.lo_op = LO_INC; w.hi_op = HI_DEC;
                w.cond = C_REV_MORE; w.target = S_RV1;
            end
            S_RD0: begin
                w.lo_op = LO_PM1;
                w.cond = C_BAD_POS; w.target = S_BAD;
            end
            S_RD1: begin
                w.rd_en = 1'b1;
            end
            S_RD2: begin
                w.rdval_en = 1'b1;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_FULL: begin
                w.st_en = 1'b1; w.st_code = ST_FULL;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            S_BAD: begin
                w.st_en = 1'b1; w.st_code = ST_BADPOS;
                w.cond = C_ALWAYS; w.target = S_DONE;
            end
            default: begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] entry(input logic [OP_W-1:0] op);
        logic [STEP_W-1:0] e;
        unique case (op)
            OP_APPEND:  e = S_AP0;
            OP_INSERT:  e = S_IN0;
            OP_DELETE:  e = S_DL0;
            OP_LOCATE:  e = S_LC0;
            OP_REVERSE: e = S_RV0;
            OP_READ:    e = S_RD0;
            default:    e = S_DONE;
        endcase
        return e;
    endfunction

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    logic              r_busy;
    logic              n_busy;
    t_uword            w;
    logic              cond_hit;
    logic              take;

    assign w = rom(r_pc);

    always_comb begin
        case (w.cond)
            C_NEVER:       cond_hit = 1'b0;
            C_ALWAYS:      cond_hit = 1'b1;
            C_FULL:        cond_hit = i_flags.full;
            C_BAD_INS:     cond_hit = i_flags.bad_ins;
            C_BAD_POS:     cond_hit = i_flags.bad_pos;
            C_HI_EQ_PM1:   cond_hit = i_flags.hi_eq_pm1;
            C_HI_EQ_POS:   cond_hit = i_flags.hi_eq_pos;
            C_LO_EQ_LEN:   cond_hit = i_flags.lo_eq_len;
            C_LO_EQ_LENM1: cond_hit = i_flags.lo_eq_lenm1;
            C_MISS_MORE:   cond_hit = i_flags.miss_more;
            C_MATCH:       cond_hit = i_flags.match;
            C_LEN_LT2:     cond_hit = i_flags.len_lt2;
            C_REV_MORE:    cond_hit = i_flags.rev_more;
            default:       cond_hit = 1'b0;
        endcase
        take = cond_hit ^ w.pol;
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_accept) begin
                n_pc   = entry(i_op);
                n_busy = 1'b1;
            end
        end else if (w.done) begin
            if (i_out_free) begin
                n_busy = 1'b0;
            end
        end else begin
            n_pc = take ? w.target : r_pc + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= S_DONE;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_ctl      = w;
    assign o_exec     = r_busy && !w.done;
    assign o_out_load = r_busy && w.done && i_out_free;
    assign o_busy     = r_busy;

`ifndef NO_ASSERTIONS
    a_pc_in_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < STEP_W'(N_STEPS)))
        else $error("step counter left the program");
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> (r_busy && (r_pc == entry($past(i_op)))))
        else $error("command not dispatched to its entry step");
    a_end_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(w.done && i_out_free))
        else $error("sequence ended outside the done step");
`endif

endmodule

// File: rtl/sle_dp.sv
// datapath: element memory, pointers, length, status and response register
// depends on sle_pkg for the control word, flags and codes

module sle_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [sle_pkg::LEN_W-1:0]      i_position,
    input  logic signed [sle_pkg::DATA_W-1:0] i_value,
    input  sle_pkg::t_uword                i_ctl,
    input  logic                           i_exec,
    input  logic                           i_out_load,
    input  logic                           i_out_ready,
    output sle_pkg::t_flags                o_flags,
    output logic                           o_out_valid,
    output logic [sle_pkg::ST_W-1:0]       o_status,
    output logic [sle_pkg::LEN_W-1:0]      o_found_position,
    output logic signed [sle_pkg::DATA_W-1:0] o_read_value,
    output logic [sle_pkg::LEN_W-1:0]      o_list_length
);
    import sle_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_lo, n_lo;
    logic [LEN_W-1:0]  r_hi, n_hi;
    logic [LEN_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_val;
    logic [ST_W-1:0]   r_st;
    logic [LEN_W-1:0]  r_found;
    logic [DATA_W-1:0] r_rdval;
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic              r_out_valid;
    logic [ST_W-1:0]   r_o_st;
    logic [LEN_W-1:0]  r_o_found;
    logic [DATA_W-1:0] r_o_rdval;
    logic [LEN_W-1:0]  r_o_len;

    logic [LEN_W-1:0]  pm1;
    logic [LEN_W-1:0]  lenm1;
    logic [LEN_W-1:0]  wa_full;
    logic [DATA_W-1:0] wd;
    logic              wr;
    logic              rd;

    assign pm1   = r_pos - LEN_W'(1);
    assign lenm1 = r_len - LEN_W'(1);
    assign wr    = i_exec && i_ctl.wr_en;
    assign rd    = i_exec && i_ctl.rd_en;

    assign wa_full = (i_ctl.wa_sel == WA_HI) ? r_hi : r_lo;

    always_comb begin
        case (i_ctl.wd_sel)
            WD_RDA:  wd = r_rd_a;
            WD_RDB:  wd = r_rd_b;
            default: wd = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[wa_full[ADDR_W-1:0]] <= wd;
        end
        if (rd) begin
            r_rd_a <= mem[r_lo[ADDR_W-1:0]];
            r_rd_b <= mem[r_hi[ADDR_W-1:0]];
        end
    end

    always_comb begin
        o_flags.full        = r_len >= LEN_W'(CAPACITY);
        o_flags.bad_pos     = (r_pos == '0) || (r_pos > r_len);
        o_flags.bad_ins     = (r_pos == '0) ||
                              ({1'b0, r_pos} > ({1'b0, r_len} + (LEN_W+1)'(1)));
        o_flags.hi_eq_pm1   = r_hi == pm1;
        o_flags.hi_eq_pos   = r_hi == r_pos;
        o_flags.lo_eq_len   = r_lo == r_len;
        o_flags.lo_eq_lenm1 = r_lo == lenm1;
        o_flags.match       = r_rd_a == r_val;
        o_flags.miss_more   = (r_rd_a != r_val) && (r_lo != r_len);
        o_flags.len_lt2     = r_len < LEN_W'(2);
        o_flags.rev_more    = (r_hi - r_lo) > LEN_W'(2);
    end

    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_len = r_len;
        if (i_exec) begin
            case (i_ctl.lo_op)
                LO_INC:   n_lo = r_lo + LEN_W'(1);
                LO_DEC:   n_lo = r_lo - LEN_W'(1);
                LO_ZERO:  n_lo = '0;
                LO_LENM1: n_lo = lenm1;
                LO_POS:   n_lo = r_pos;
                LO_PM1:   n_lo = pm1;
                default:  n_lo = r_lo;
            endcase
            case (i_ctl.hi_op)
                HI_INC:   n_hi = r_hi + LEN_W'(1);
                HI_DEC:   n_hi = r_hi - LEN_W'(1);
                HI_LEN:   n_hi = r_len;
                HI_LENM1: n_hi = lenm1;
                HI_PM1:   n_hi = pm1;
                default:  n_hi = r_hi;
            endcase
            case (i_ctl.len_op)
                LEN_INC: n_len = r_len + LEN_W'(1);
                LEN_DEC: n_len = r_len - LEN_W'(1);
                default: n_len = r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len <= n_len;
            if (i_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_accept) begin
            r_pos   <= i_position;
            r_val   <= i_value;
            r_st    <= ST_OK;
            r_found <= '0;
            r_rdval <= '0;
        end else if (i_exec) begin
            if (i_ctl.st_en) begin
                r_st <= i_ctl.st_code;
            end
            if (i_ctl.found_en) begin
                r_found <= r_lo;
            end
            if (i_ctl.rdval_en) begin
                r_rdval <= r_rd_a;
            end
        end
        if (i_out_load) begin
            r_o_st    <= r_st;
            r_o_found <= r_found;
            r_o_rdval <= r_rdval;
            r_o_len   <= r_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_st;
    assign o_found_position = r_o_found;
    assign o_read_value     = r_o_rdval;
    assign o_list_length    = r_o_len;

`ifndef NO_ASSERTIONS
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(CAPACITY))
        else $error("length above capacity");
    a_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |-> (wa_full < LEN_W'(CAPACITY)))
        else $error("element write outside the store");
    a_len_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |-> $past(i_exec))
        else $error("length changed outside a command step");
    a_rsp_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_out_load))
        else $error("response valid without a load");
`endif

endmodule

// File: rtl/sequential_list_engine.sv
// top level of the sequential list engine: sequencer, datapath and channel glue
// depends on sle_pkg, sle_if, sle_seq and sle_dp
//
// channel   dir  handshake        payload
// i_cmd     in   valid / ready    op, position, value
// o_rsp     out  valid / ready    status, found_position, read_value, list_length
//
// one command in flight; ready is high while the sequencer is idle
// insert and delete shift one element per loop pass, locate scans one element per pass
// (an empty list goes straight to not found), reverse swaps one pair per pass, and
// append and read run straight through; the done step then posts the response;
// the loops are set by the single write port and registered reads of the store
// synchronous reset clears the length and the control; the store is not cleared
// a response not yet taken holds the next command in its done step

module sequential_list_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sle_cmd_if.sink   i_cmd,
    sle_rsp_if.source o_rsp
);
    import sle_pkg::*;

    t_uword ctl;
    t_flags flags;
    logic   exec;
    logic   out_load;
    logic   busy;
    logic   out_valid;
    logic   out_free;
    logic   accept;

    assign i_cmd.ready = !busy;
    assign accept      = i_cmd.valid && !busy;
    assign out_free    = !out_valid || o_rsp.ready;
    assign o_rsp.valid = out_valid;

    sle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_cmd.op),
        .i_flags    (flags),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_exec     (exec),
        .o_out_load (out_load),
        .o_busy     (busy)
    );

    sle_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_position       (i_cmd.position),
        .i_value          (i_cmd.value),
        .i_ctl            (ctl),
        .i_exec           (exec),
        .i_out_load       (out_load),
        .i_out_ready      (o_rsp.ready),
        .o_flags          (flags),
        .o_out_valid      (out_valid),
        .o_status         (o_rsp.status),
        .o_found_position (o_rsp.found_position),
        .o_read_value     (o_rsp.read_value),
        .o_list_length    (o_rsp.list_length)
    );

endmodule
